[src/tsra_pkg.sv]
package tsra_pkg;

  localparam int SENSOR_COUNT       = 3;
  localparam int DEFAULT_RING_DEPTH = 8;

  localparam int WIDTH_W = 16;
  localparam int MM_W    = 8;
  localparam int CH_W    = 2;
  localparam int CFG_W   = 16;

  localparam logic [15:0] SCALE_RESET    = 16'd22599;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;
  localparam logic [7:0]  MAXRANGE_RESET = 8'd250;

  typedef enum logic [1:0] {
    CFG_MM_SCALE     = 2'd0,
    CFG_ECHO_TIMEOUT = 2'd1,
    CFG_MAX_RANGE    = 2'd2
  } cfg_index_t;

  typedef enum logic [CH_W-1:0] {
    CH_LEFT   = 2'd0,
    CH_CENTER = 2'd1,
    CH_RIGHT  = 2'd2
  } channel_t;

  typedef struct packed {
    logic [15:0] mm_scale_q16;
    logic [15:0] echo_timeout_us;
    logic [7:0]  max_range_mm;
  } cfg_t;

  // Pipeline control shared by the top level and the ring
  typedef struct packed {
    logic accept;
    logic adv1;
    logic adv2;
    logic s1_valid;
    logic s2_valid;
  } pipe_ctl_t;

endpackage

[src/tsra_convert.sv]
module tsra_convert (
  input  logic [tsra_pkg::WIDTH_W-1:0] echo_width_us,
  input  tsra_pkg::cfg_t               cfg,
  output logic [tsra_pkg::MM_W-1:0]    mm
);
  import tsra_pkg::*;

  logic [15:0] width_sel;
  logic [14:0] half_width;
  logic [30:0] product;
  logic [14:0] mm_full;

  always_comb begin
    // Missing echo: substitute half the timeout
    if (echo_width_us == '0) begin
      width_sel = {1'b0, cfg.echo_timeout_us[15:1]};
    end else begin
      width_sel = echo_width_us;
    end
    half_width = width_sel[15:1];
    product    = 31'(half_width) * 31'(cfg.mm_scale_q16);
    mm_full    = product[30:16];
    if (mm_full > 15'(cfg.max_range_mm)) begin
      mm = cfg.max_range_mm;
    end else begin
      mm = mm_full[7:0];
    end
  end

endmodule

[src/tsra_ring.sv]
module tsra_ring #(
  parameter int RING_DEPTH = tsra_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tsra_pkg::pipe_ctl_t       ctl,
  input  logic [tsra_pkg::MM_W-1:0] mm,
  output tsra_pkg::channel_t        channel,
  output logic [tsra_pkg::MM_W-1:0] next_avg
);
  import tsra_pkg::*;

  localparam int POS_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int MEM_DEPTH = SENSOR_COUNT * RING_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SUM_W     = $clog2(RING_DEPTH * 255 + 1);
  localparam int DIV_SHIFT = SUM_W + $clog2(RING_DEPTH);
  localparam int RECIP_W   = SUM_W + 2;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  logic [MM_W-1:0]   mem [MEM_DEPTH];
  logic [MM_W-1:0]   rd_data;

  channel_t          next_sensor;
  logic [POS_W-1:0]  pos [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] wrapped;
  logic [SUM_W-1:0]  sum [SENSOR_COUNT];

  channel_t          s1_ch;
  logic [POS_W-1:0]  s1_pos;
  logic              s1_old_valid;
  channel_t          s2_ch;
  logic [POS_W-1:0]  s2_pos;
  logic [MM_W-1:0]   s2_old;

  logic [POS_W-1:0]  cur_pos;
  logic              cur_wrap;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [SUM_W-1:0]  new_sum;
  logic [PROD_W-1:0] quot_full;

  always_comb begin
    cur_pos   = pos[next_sensor];
    cur_wrap  = (cur_pos == POS_W'(RING_DEPTH - 1));
    rd_addr   = ADDR_W'(next_sensor) * ADDR_W'(RING_DEPTH) + ADDR_W'(cur_pos);
    wr_addr   = ADDR_W'(s2_ch) * ADDR_W'(RING_DEPTH) + ADDR_W'(s2_pos);
    new_sum   = sum[s2_ch] - SUM_W'(s2_old) + SUM_W'(mm);
    // Exact floor division by the ring depth through a rounded-up reciprocal
    quot_full = PROD_W'(new_sum) * PROD_W'(RECIP);
    next_avg  = quot_full[DIV_SHIFT +: MM_W];
    channel   = s2_ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_sensor <= CH_LEFT;
      wrapped     <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        pos[i] <= '0;
        sum[i] <= '0;
      end
    end else begin
      if (ctl.accept) begin
        next_sensor <= (next_sensor == CH_RIGHT) ? CH_LEFT : channel_t'(next_sensor + 2'd1);
        if (cur_wrap) begin
          pos[next_sensor]     <= '0;
          wrapped[next_sensor] <= 1'b1;
        end else begin
          pos[next_sensor] <= cur_pos + POS_W'(1);
        end
      end
      if (ctl.adv2) begin
        sum[s2_ch] <= new_sum;
      end
    end
  end

  // Entries are written in ring order, so an entry is stale only until its ring wraps
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      rd_data      <= mem[rd_addr];
      s1_ch        <= next_sensor;
      s1_pos       <= cur_pos;
      s1_old_valid <= wrapped[next_sensor];
    end
    if (ctl.adv1) begin
      s2_ch  <= s1_ch;
      s2_pos <= s1_pos;
      s2_old <= s1_old_valid ? rd_data : '0;
    end
    if (ctl.adv2) begin
      mem[wr_addr] <= mm;
    end
  end

`ifndef SYNTH
  a_sum_covers_old: assert property (@(posedge clk) disable iff (rst)
    ctl.adv2 |-> sum[s2_ch] >= SUM_W'(s2_old))
    else $error("running sum smaller than the evicted sample");

  a_no_ring_overlap: assert property (@(posedge clk) disable iff (rst)
    ctl.s1_valid && ctl.s2_valid |-> s1_ch != s2_ch)
    else $error("two requests in flight on the same sensor ring");
`endif

endmodule

[src/three_sonar_range_averager.sv]
// Three-sensor sonar range averager. Each accepted request carries one echo
// width and goes to the left, center and right sensor in turn, starting with
// left after reset. The width is converted to millimetres through the Q0.16
// scale, clamped at max_range_mm, and written into that sensor's sample ring;
// every result carries the channel, the new distance and the floor averages of
// all three rings. One request is accepted per cycle unless the output stalls;
// a result passes through the input register, the conversion multiplier and
// the ring update with its registered sample memory read, one stage each. The
// rings read as zero until written, so no clearing pass follows reset.
// Configuration must be written only while idle; the block does not check it.
module three_sonar_range_averager #(
  parameter int RING_DEPTH = tsra_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [1:0]                   write_index,
  input  logic [tsra_pkg::CFG_W-1:0]   write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tsra_pkg::WIDTH_W-1:0] echo_width_us,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tsra_pkg::CH_W-1:0]    sensor_channel,
  output logic [tsra_pkg::MM_W-1:0]    distance_mm,
  output logic [tsra_pkg::MM_W-1:0]    left_average_mm,
  output logic [tsra_pkg::MM_W-1:0]    center_average_mm,
  output logic [tsra_pkg::MM_W-1:0]    right_average_mm
);
  import tsra_pkg::*;

  cfg_t              cfg;
  pipe_ctl_t         ctl;

  logic              p1_valid;
  logic [WIDTH_W-1:0] p1_width;
  logic              p2_valid;
  logic [MM_W-1:0]   p2_mm;

  logic              out_free;
  logic              p2_free;
  logic              p1_free;
  logic [MM_W-1:0]   conv_mm;
  channel_t          ring_ch;
  logic [MM_W-1:0]   ring_avg;

  always_comb begin
    out_free     = !out_valid || !out_stall;
    ctl.adv2     = p2_valid && out_free;
    p2_free      = !p2_valid || ctl.adv2;
    ctl.adv1     = p1_valid && p2_free;
    p1_free      = !p1_valid || ctl.adv1;
    ctl.accept   = in_valid && p1_free;
    ctl.s1_valid = p1_valid;
    ctl.s2_valid = p2_valid;
    in_stall     = !p1_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mm_scale_q16    <= SCALE_RESET;
      cfg.echo_timeout_us <= TIMEOUT_RESET;
      cfg.max_range_mm    <= MAXRANGE_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        CFG_MM_SCALE:     cfg.mm_scale_q16    <= write_data[15:0];
        CFG_ECHO_TIMEOUT: cfg.echo_timeout_us <= write_data[15:0];
        CFG_MAX_RANGE:    cfg.max_range_mm    <= write_data[7:0];
        default: ;
      endcase
    end
  end

  tsra_convert u_convert (
    .echo_width_us (p1_width),
    .cfg           (cfg),
    .mm            (conv_mm)
  );

  tsra_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .mm       (p2_mm),
    .channel  (ring_ch),
    .next_avg (ring_avg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid          <= 1'b0;
      p2_valid          <= 1'b0;
      out_valid         <= 1'b0;
      left_average_mm   <= '0;
      center_average_mm <= '0;
      right_average_mm  <= '0;
    end else begin
      if (p1_free) begin
        p1_valid <= in_valid;
      end
      if (p2_free) begin
        p2_valid <= p1_valid;
      end
      if (out_free) begin
        out_valid <= p2_valid;
      end
      // Average fields double as the per-sensor average state
      if (ctl.adv2) begin
        unique case (ring_ch)
          CH_LEFT:   left_average_mm   <= ring_avg;
          CH_CENTER: center_average_mm <= ring_avg;
          CH_RIGHT:  right_average_mm  <= ring_avg;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      p1_width <= echo_width_us;
    end
    if (ctl.adv1) begin
      p2_mm <= conv_mm;
    end
    if (ctl.adv2) begin
      sensor_channel <= ring_ch;
      distance_mm    <= p2_mm;
    end
  end

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> p1_valid && p2_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  a_result_from_p2: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(p2_valid))
    else $error("result raised without a request in the ring stage");
`endif

endmodule

[tb/three_sonar_range_averager_tb.sv]
module three_sonar_range_averager_tb;
  import tsra_pkg::*;

  localparam int RING_DEPTH = DEFAULT_RING_DEPTH;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS = 10;
  // index with no register behind it; writes there must be ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    channel_t    channel;
    logic [7:0]  distance;
    logic [7:0]  left_avg;
    logic [7:0]  center_avg;
    logic [7:0]  right_avg;
  } range_result_t;

  logic              clk;
  logic              rst;
  logic              write_enable;
  logic [1:0]        write_index;
  logic [CFG_W-1:0]  write_data;
  logic              in_valid;
  logic              in_stall;
  logic [15:0]       echo_width_us;
  logic              out_valid;
  logic              out_stall;
  logic [CH_W-1:0]   sensor_channel;
  logic [7:0]        distance_mm;
  logic [7:0]        left_average_mm;
  logic [7:0]        center_average_mm;
  logic [7:0]        right_average_mm;

  three_sonar_range_averager #(.RING_DEPTH(RING_DEPTH)) uut (
    .clk               (clk),
    .rst               (rst),
    .write_enable      (write_enable),
    .write_index       (write_index),
    .write_data        (write_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .echo_width_us     (echo_width_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sensor_channel    (sensor_channel),
    .distance_mm       (distance_mm),
    .left_average_mm   (left_average_mm),
    .center_average_mm (center_average_mm),
    .right_average_mm  (right_average_mm)
  );

  // predictor state
  logic [15:0] cfg_scale;
  logic [15:0] cfg_timeout;
  logic [7:0]  cfg_ceiling;
  channel_t    next_channel;
  int          ring_pos [SENSOR_COUNT];
  logic [7:0]  ring_mm [SENSOR_COUNT][RING_DEPTH];
  logic [10:0] ring_total [SENSOR_COUNT];

  range_result_t pending_ranges [$];
  int            mismatch_count;
  int            quiet_cycles;
  bit            steady_stream;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic range_result_t predict_ranges(input logic [15:0] width);
    logic [15:0]   w;
    logic [31:0]   product;
    logic [7:0]    mm;
    int            c;
    range_result_t r;
    w = (width == 16'd0) ? {1'b0, cfg_timeout[15:1]} : width;
    product = {17'd0, w[15:1]} * {16'd0, cfg_scale};
    mm = (product[31:16] > {8'd0, cfg_ceiling}) ? cfg_ceiling : product[23:16];
    c = int'(next_channel);
    ring_total[c] = ring_total[c] - {3'd0, ring_mm[c][ring_pos[c]]} + {3'd0, mm};
    ring_mm[c][ring_pos[c]] = mm;
    ring_pos[c] = (ring_pos[c] == RING_DEPTH - 1) ? 0 : ring_pos[c] + 1;
    r.channel = next_channel;
    r.distance = mm;
    r.left_avg = 8'(ring_total[CH_LEFT] / RING_DEPTH);
    r.center_avg = 8'(ring_total[CH_CENTER] / RING_DEPTH);
    r.right_avg = 8'(ring_total[CH_RIGHT] / RING_DEPTH);
    next_channel = (c == SENSOR_COUNT - 1) ? CH_LEFT : channel_t'(c + 1);
    return r;
  endfunction

  // Call at a falling edge; returns at a falling edge.
  task automatic send_echo(input logic [15:0] width);
    int gap;
    if (!steady_stream && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    echo_width_us <= width;
    do @(posedge clk); while (in_stall);
    pending_ranges.push_back(predict_ranges(width));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_ranges.size() != 0);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= value;
    @(negedge clk);
    write_enable <= 1'b0;
    case (idx)
      CFG_MM_SCALE:     cfg_scale = value;
      CFG_ECHO_TIMEOUT: cfg_timeout = value;
      CFG_MAX_RANGE:    cfg_ceiling = value[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  // Defaults: no echo saturates, small widths stay below the ceiling.
  task automatic test_reset_defaults();
    logic [15:0] widths [$];
    widths = {16'd0, 16'd1, 16'd2, 16'd3, 16'd65535, 16'hAAAA, 16'h5555,
              16'd100, 16'd740, 16'd1480, 16'd1500, 16'd0, 16'd4};
    foreach (widths[i]) send_echo(widths[i]);
    wait_for_results();
  endtask

  task automatic test_config_extremes();
    write_register(CFG_MM_SCALE, 16'd0);
    send_echo(16'd65535);
    send_echo(16'd0);
    wait_for_results();
    write_register(CFG_MM_SCALE, 16'd65535);
    write_register(CFG_MAX_RANGE, 16'hFFFF);
    send_echo(16'd65535);
    send_echo(16'd511);
    send_echo(16'd0);
    wait_for_results();
    // substitute for a missing echo collapses to zero
    write_register(CFG_ECHO_TIMEOUT, 16'd0);
    send_echo(16'd0);
    wait_for_results();
    write_register(CFG_ECHO_TIMEOUT, 16'd1);
    send_echo(16'd0);
    wait_for_results();
    write_register(CFG_ECHO_TIMEOUT, 16'd65535);
    send_echo(16'd0);
    send_echo(16'd1);
    wait_for_results();
    write_register(CFG_MAX_RANGE, 16'h0000);
    send_echo(16'd65535);
    send_echo(16'd300);
    wait_for_results();
    write_register(CFG_UNUSED, 16'hFFFF);
    write_register(CFG_MAX_RANGE, 16'h00C8);
    send_echo(16'd0);
    send_echo(16'd200);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0:       write_register(CFG_MM_SCALE, 16'($urandom_range(1, 65535)));
        1:       write_register(CFG_MM_SCALE, 16'($urandom_range(1, 2)));
        default: write_register(CFG_MM_SCALE, 16'($urandom_range(15000, 30000)));
      endcase
      write_register(CFG_ECHO_TIMEOUT, 16'($urandom));
      case ($urandom_range(0, 3))
        0:       write_register(CFG_MAX_RANGE, {8'($urandom), 8'd0});
        1:       write_register(CFG_MAX_RANGE, {8'($urandom), 8'd255});
        default: write_register(CFG_MAX_RANGE, 16'($urandom));
      endcase
      if ($urandom_range(0, 2) == 0) write_register(CFG_UNUSED, 16'($urandom));
      for (int n = 0; n < 110; n++) begin
        // hold off once until the pipeline has emptied
        if (phase == 3 && n == 55) wait_for_results();
        send_echo(pick_width());
      end
      wait_for_results();
    end
  endtask

  task automatic test_steady_stream();
    write_register(CFG_MM_SCALE, SCALE_RESET);
    write_register(CFG_ECHO_TIMEOUT, TIMEOUT_RESET);
    write_register(CFG_MAX_RANGE, {8'd0, MAXRANGE_RESET});
    steady_stream = 1'b1;
    for (int n = 0; n < 150; n++) send_echo(pick_width());
    wait_for_results();
  endtask

  // receiver stalls in bursts
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady_stream && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    range_result_t got;
    range_result_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("three_sonar_range_averager test failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got.channel = channel_t'(sensor_channel);
      got.distance = distance_mm;
      got.left_avg = left_average_mm;
      got.center_avg = center_average_mm;
      got.right_avg = right_average_mm;
      if (pending_ranges.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: ch %0d dist %0d avg %0d/%0d/%0d",
                   got.channel, got.distance, got.left_avg, got.center_avg,
                   got.right_avg);
      end else begin
        want = pending_ranges.pop_front();
        if (got != want) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected ch %0d dist %0d avg %0d/%0d/%0d",
                     want.channel, want.distance, want.left_avg, want.center_avg,
                     want.right_avg);
            $display("          got ch %0d dist %0d avg %0d/%0d/%0d",
                     got.channel, got.distance, got.left_avg, got.center_avg,
                     got.right_avg);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    write_enable = 1'b0;
    write_index = '0;
    write_data = '0;
    in_valid = 1'b0;
    echo_width_us = '0;
    steady_stream = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    cfg_scale = SCALE_RESET;
    cfg_timeout = TIMEOUT_RESET;
    cfg_ceiling = MAXRANGE_RESET;
    next_channel = CH_LEFT;
    for (int c = 0; c < SENSOR_COUNT; c++) begin
      ring_pos[c] = 0;
      ring_total[c] = '0;
      for (int k = 0; k < RING_DEPTH; k++) ring_mm[c][k] = '0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_random_traffic();
    test_steady_stream();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_ranges.size() == 0) begin
      $display("three_sonar_range_averager test passed");
    end else begin
      $display("three_sonar_range_averager test failed");
    end
    $finish;
  end

endmodule
